// ----- hw/rtl/cpbc_pkg.sv -----
// Shared types, constants, arithmetic helpers and microcode for the roll-balance controller.
`default_nettype none

package cpbc_pkg;

    localparam int unsigned GAIN_W   = 24;
    localparam int unsigned ROLL_W   = 25;
    localparam int unsigned RATE_W   = 28;
    localparam int unsigned ACCEL_W  = 25;
    localparam int unsigned DRIVE_W  = 24;
    localparam int unsigned CFG_W    = 25;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned INT_W    = 20;
    localparam int unsigned OPB_W    = 38;
    localparam int unsigned PROD_W   = GAIN_W + OPB_W;
    localparam int unsigned ACC_W    = 48;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned IN_W     = 80;

    localparam logic signed [ROLL_W:0]   ROLL_LIM  = (ROLL_W + 1)'(50 * 65536);
    localparam logic signed [OPB_W:0]    INT_LIM   = (OPB_W + 1)'(5 * 65536);
    localparam logic signed [ACC_W-1:0]  DRIVE_LIM = ACC_W'(100 * 65536);

    typedef enum logic [IDX_W-1:0] {
        REG_ANGLE_KP     = 3'd0,
        REG_ANGLE_KI     = 3'd1,
        REG_ANGLE_KD     = 3'd2,
        REG_RATE_KP      = 3'd3,
        REG_RATE_KI      = 3'd4,
        REG_RATE_KD      = 3'd5,
        REG_ANGLE_TARGET = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        G_AKP = 3'd0,
        G_AKI = 3'd1,
        G_AKD = 3'd2,
        G_RKP = 3'd3,
        G_RKI = 3'd4,
        G_RKD = 3'd5
    } t_gsel;

    typedef enum logic [2:0] {
        OP_ERR   = 3'd0,
        OP_AINT  = 3'd1,
        OP_RINT  = 3'd2,
        OP_RATE  = 3'd3,
        OP_ACCEL = 3'd4
    } t_osel;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    typedef enum logic [1:0] {
        ERR_HOLD  = 2'd0,
        ERR_OUTER = 2'd1,
        ERR_INNER = 2'd2
    } t_err_op;

    typedef enum logic [1:0] {
        INT_HOLD  = 2'd0,
        INT_ANGLE = 2'd1,
        INT_RATE  = 2'd2
    } t_int_op;

    typedef struct packed {
        t_gsel   gsel;
        t_osel   osel;
        t_acc_op acc_op;
        t_err_op err_op;
        t_int_op int_op;
        logic    jmp_gate;
        logic    emit;
    } t_cword;

    typedef struct packed {
        logic signed [GAIN_W-1:0] angle_kp;
        logic signed [GAIN_W-1:0] angle_ki;
        logic signed [GAIN_W-1:0] angle_kd;
        logic signed [GAIN_W-1:0] rate_kp;
        logic signed [GAIN_W-1:0] rate_ki;
        logic signed [GAIN_W-1:0] rate_kd;
        logic signed [ROLL_W-1:0] angle_target;
    } t_gains;

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll_angle;
        logic signed [RATE_W-1:0]  roll_rate;
        logic signed [ACCEL_W-1:0] lateral_accel;
    } t_sample;

    typedef struct packed {
        logic                      gate_out;
        logic                      clip;
        logic signed [DRIVE_W-1:0] drive;
    } t_status;

    localparam logic [STEP_W-1:0] STEP_EMIT = 4'd10;

    localparam t_cword CW_NOP = '{gsel: G_AKP, osel: OP_ERR, acc_op: ACC_HOLD,
                                  err_op: ERR_HOLD, int_op: INT_HOLD,
                                  jmp_gate: 1'b0, emit: 1'b0};

    function automatic logic signed [INT_W-1:0] integrate(
        input logic signed [INT_W-1:0] acc,
        input logic signed [OPB_W-1:0] e
    );
        logic signed [OPB_W:0] s;
        s = {{(OPB_W + 1 - INT_W){acc[INT_W-1]}}, acc} + {e[OPB_W-1], e};
        if (s > INT_LIM || s < -INT_LIM) begin
            return '0;
        end
        return s[INT_W-1:0];
    endfunction

    function automatic t_cword ucode(input logic [STEP_W-1:0] step);
        t_cword cw;
        cw = CW_NOP;
        unique case (step)
            4'd0: begin
                cw.err_op   = ERR_OUTER;
                cw.jmp_gate = 1'b1;
            end
            4'd1: begin
                cw.int_op = INT_ANGLE;
                cw.gsel   = G_AKP;
                cw.osel   = OP_ERR;
            end
            4'd2: begin
                cw.gsel   = G_AKI;
                cw.osel   = OP_AINT;
                cw.acc_op = ACC_LOAD;
            end
            4'd3: begin
                cw.gsel   = G_AKD;
                cw.osel   = OP_RATE;
                cw.acc_op = ACC_ADD;
            end
            4'd4: cw.acc_op = ACC_ADD;
            4'd5: cw.err_op = ERR_INNER;
            4'd6: begin
                cw.int_op = INT_RATE;
                cw.gsel   = G_RKP;
                cw.osel   = OP_ERR;
            end
            4'd7: begin
                cw.gsel   = G_RKI;
                cw.osel   = OP_RINT;
                cw.acc_op = ACC_LOAD;
            end
            4'd8: begin
                cw.gsel   = G_RKD;
                cw.osel   = OP_ACCEL;
                cw.acc_op = ACC_ADD;
            end
            4'd9: cw.acc_op = ACC_ADD;
            4'd10: cw.emit = 1'b1;
            default: cw = CW_NOP;
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cpbc_datapath.sv -----
// Datapath: shared multiplier, accumulator, error register and the two integrators.
`default_nettype none

module cpbc_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step_en,
    input  wire cpbc_pkg::t_cword i_cw,
    input  wire cpbc_pkg::t_gains i_gains,
    input  wire cpbc_pkg::t_sample i_sample,
    output cpbc_pkg::t_status     o_status
);

    logic signed [cpbc_pkg::GAIN_W-1:0]  w_gain;
    logic signed [cpbc_pkg::OPB_W-1:0]   w_opb;
    logic signed [cpbc_pkg::PROD_W-1:0]  w_prod;
    logic signed [cpbc_pkg::ACC_W-1:0]   w_pterm;
    logic signed [cpbc_pkg::ROLL_W:0]    w_roll_x;
    logic signed [cpbc_pkg::ROLL_W:0]    w_err_outer;
    logic signed [cpbc_pkg::OPB_W-1:0]   w_rate_x;

    logic signed [cpbc_pkg::PROD_W-1:0]  r_prod;
    logic signed [cpbc_pkg::ACC_W-1:0]   r_acc;
    logic signed [cpbc_pkg::OPB_W-1:0]   r_err;
    logic signed [cpbc_pkg::INT_W-1:0]   r_aint;
    logic signed [cpbc_pkg::INT_W-1:0]   r_rint;
    logic signed [cpbc_pkg::ACC_W-1:0]   n_acc;
    logic signed [cpbc_pkg::OPB_W-1:0]   n_err;

    always_comb begin
        unique case (i_cw.gsel)
            cpbc_pkg::G_AKP: w_gain = i_gains.angle_kp;
            cpbc_pkg::G_AKI: w_gain = i_gains.angle_ki;
            cpbc_pkg::G_AKD: w_gain = i_gains.angle_kd;
            cpbc_pkg::G_RKP: w_gain = i_gains.rate_kp;
            cpbc_pkg::G_RKI: w_gain = i_gains.rate_ki;
            cpbc_pkg::G_RKD: w_gain = i_gains.rate_kd;
            default:         w_gain = '0;
        endcase
    end

    assign w_rate_x = {{(cpbc_pkg::OPB_W - cpbc_pkg::RATE_W){i_sample.roll_rate[cpbc_pkg::RATE_W-1]}},
                       i_sample.roll_rate};

    always_comb begin
        unique case (i_cw.osel)
            cpbc_pkg::OP_ERR:   w_opb = r_err;
            cpbc_pkg::OP_AINT:  w_opb = {{(cpbc_pkg::OPB_W - cpbc_pkg::INT_W){r_aint[cpbc_pkg::INT_W-1]}},
                                         r_aint};
            cpbc_pkg::OP_RINT:  w_opb = {{(cpbc_pkg::OPB_W - cpbc_pkg::INT_W){r_rint[cpbc_pkg::INT_W-1]}},
                                         r_rint};
            cpbc_pkg::OP_RATE:  w_opb = w_rate_x;
            cpbc_pkg::OP_ACCEL: w_opb = {{(cpbc_pkg::OPB_W - cpbc_pkg::ACCEL_W)
                                          {i_sample.lateral_accel[cpbc_pkg::ACCEL_W-1]}},
                                         i_sample.lateral_accel};
            default:            w_opb = '0;
        endcase
    end

    assign w_prod  = w_gain * w_opb;
    assign w_pterm = {{(cpbc_pkg::ACC_W - cpbc_pkg::PROD_W + cpbc_pkg::FRAC_W)
                       {r_prod[cpbc_pkg::PROD_W-1]}},
                      r_prod[cpbc_pkg::PROD_W-1:cpbc_pkg::FRAC_W]};

    assign w_roll_x    = {i_sample.roll_angle[cpbc_pkg::ROLL_W-1], i_sample.roll_angle};
    assign w_err_outer = w_roll_x - {i_gains.angle_target[cpbc_pkg::ROLL_W-1], i_gains.angle_target};

    always_comb begin
        unique case (i_cw.acc_op)
            cpbc_pkg::ACC_LOAD: n_acc = w_pterm;
            cpbc_pkg::ACC_ADD:  n_acc = r_acc + w_pterm;
            default:            n_acc = r_acc;
        endcase
    end

    always_comb begin
        unique case (i_cw.err_op)
            cpbc_pkg::ERR_OUTER: n_err = {{(cpbc_pkg::OPB_W - cpbc_pkg::ROLL_W - 1)
                                           {w_err_outer[cpbc_pkg::ROLL_W]}}, w_err_outer};
            cpbc_pkg::ERR_INNER: n_err = w_rate_x - r_acc[cpbc_pkg::OPB_W-1:0];
            default:             n_err = r_err;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_step_en) begin
            r_prod <= w_prod;
            r_acc  <= n_acc;
            r_err  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aint <= '0;
            r_rint <= '0;
        end else if (i_step_en) begin
            if (i_cw.int_op == cpbc_pkg::INT_ANGLE) begin
                r_aint <= cpbc_pkg::integrate(r_aint, r_err);
            end
            if (i_cw.int_op == cpbc_pkg::INT_RATE) begin
                r_rint <= cpbc_pkg::integrate(r_rint, r_err);
            end
        end
    end

    assign o_status.gate_out = (w_roll_x > cpbc_pkg::ROLL_LIM) || (w_roll_x < -cpbc_pkg::ROLL_LIM);
    assign o_status.clip     = (r_acc > cpbc_pkg::DRIVE_LIM) || (r_acc < -cpbc_pkg::DRIVE_LIM);
    assign o_status.drive    = r_acc[cpbc_pkg::DRIVE_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/cascaded_pid_balance_controller_core.sv -----
// Top level of the cascaded angle/rate PID roll-balance controller.
`default_nettype none

// Each sample runs through an 11-step microprogram on one shared 24x38 multiplier;
// a new sample is taken the cycle after the result leaves the sequencer, so the block
// takes no new sample before it is through with the last one. A sample whose roll
// angle is outside plus or minus 50 skips to the last step. The result sits in an
// output register, so a new sample can start while it waits; a full output register
// stalls only the last step. The user must write gains and the angle target through
// the register port only while idle; the block itself does not enforce this.
module cascaded_pid_balance_controller_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // roll_angle[24:0], roll_rate[52:25], lateral_accel[77:53], zero[79:78]
    input  wire logic [cpbc_pkg::IN_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // drive[23:0]
    output logic [cpbc_pkg::DRIVE_W-1:0]       o_m_tdata,
    // running[0], clipped[1]
    output logic [1:0]                         o_m_tuser,
    input  wire logic                          i_cfg_wen,
    input  wire logic [cpbc_pkg::IDX_W-1:0]    i_cfg_addr,
    input  wire logic [cpbc_pkg::CFG_W-1:0]    i_cfg_wdata
);

    logic                             r_busy;
    logic [cpbc_pkg::STEP_W-1:0]      r_step;
    logic                             r_run;
    cpbc_pkg::t_sample                r_sample;
    cpbc_pkg::t_gains                 r_gains;
    logic                             r_ovalid;
    logic [cpbc_pkg::DRIVE_W-1:0]     r_odrive;
    logic                             r_orun;
    logic                             r_oclip;

    cpbc_pkg::t_cword                 w_cw;
    cpbc_pkg::t_status                w_status;
    logic                             w_accept;
    logic                             w_emit_ok;
    logic                             w_step_en;

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_cw      = r_busy ? cpbc_pkg::ucode(r_step) : cpbc_pkg::CW_NOP;
    assign w_emit_ok = !r_ovalid || i_m_tready;
    assign w_step_en = r_busy && !w_cw.emit;

    cpbc_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step_en (w_step_en),
        .i_cw      (w_cw),
        .i_gains   (r_gains),
        .i_sample  (r_sample),
        .o_status  (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample.roll_angle    <= i_s_tdata[24:0];
            r_sample.roll_rate     <= i_s_tdata[52:25];
            r_sample.lateral_accel <= i_s_tdata[77:53];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_run  <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (w_cw.emit) begin
                if (w_emit_ok) begin
                    r_busy <= 1'b0;
                end
            end else if (w_cw.jmp_gate) begin
                r_run <= !w_status.gate_out;
                if (w_status.gate_out) begin
                    r_step <= cpbc_pkg::STEP_EMIT;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_busy && w_cw.emit && w_emit_ok) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && w_cw.emit && w_emit_ok) begin
            r_orun   <= r_run;
            r_oclip  <= r_run && w_status.clip;
            r_odrive <= (r_run && !w_status.clip) ? w_status.drive : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.angle_kp     <= 24'sd65536;
            r_gains.angle_ki     <= 24'sd65536;
            r_gains.angle_kd     <= '0;
            r_gains.rate_kp      <= 24'sd65536;
            r_gains.rate_ki      <= 24'sd65536;
            r_gains.rate_kd      <= '0;
            r_gains.angle_target <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                cpbc_pkg::REG_ANGLE_KP:     r_gains.angle_kp     <= i_cfg_wdata[23:0];
                cpbc_pkg::REG_ANGLE_KI:     r_gains.angle_ki     <= i_cfg_wdata[23:0];
                cpbc_pkg::REG_ANGLE_KD:     r_gains.angle_kd     <= i_cfg_wdata[23:0];
                cpbc_pkg::REG_RATE_KP:      r_gains.rate_kp      <= i_cfg_wdata[23:0];
                cpbc_pkg::REG_RATE_KI:      r_gains.rate_ki      <= i_cfg_wdata[23:0];
                cpbc_pkg::REG_RATE_KD:      r_gains.rate_kd      <= i_cfg_wdata[23:0];
                cpbc_pkg::REG_ANGLE_TARGET: r_gains.angle_target <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_s_tready = !r_busy;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odrive;
    assign o_m_tuser  = {r_oclip, r_orun};

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= cpbc_pkg::STEP_EMIT)
        else $error("step counter ran past the last step");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && r_step == '0)
        else $error("accepted item did not start the program");

    a_gated_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> !o_m_tuser[1] && o_m_tdata == '0)
        else $error("gated result carries drive or clip flag");

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tdata == '0)
        else $error("clipped result carries nonzero drive");

    a_emit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && w_cw.emit && !w_emit_ok |=> r_busy && r_step == cpbc_pkg::STEP_EMIT)
        else $error("result step left while output register was full");

endmodule

`default_nettype wire
